// ===== hw/rtl/sslit_pkg.sv =====
// Shared constants, codes and chain types for the set signature lookup table.
`timescale 1ns / 1ps
`default_nettype none

package sslit_pkg;

	localparam int MAX_SETS_DEF = 64;
	localparam int MAX_COLUMNS_DEF = 64;
	localparam int RESULT_CAP = 64;

	// The chain types are sized for the largest legal table.
	localparam int KEY_W = 64;
	localparam int CNT_W = 11;

	localparam logic [1:0] MODE_WITH = 2'd0;
	localparam logic [1:0] MODE_WITHOUT = 2'd1;
	localparam logic [1:0] MODE_CONTAINS = 2'd2;
	localparam logic [1:0] MODE_SUPERSETS = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_ERR = 2'd2;

	localparam logic [1:0] TOK_FETCH = 2'd0;
	localparam logic [1:0] TOK_MATCH = 2'd1;
	localparam logic [1:0] TOK_SUPER = 2'd2;

	typedef struct packed {
		logic             valid;
		logic [1:0]       op;
		logic [KEY_W-1:0] key;
	} token_t;

	typedef struct packed {
		logic [CNT_W-1:0] src;
		logic [CNT_W-1:0] start;
		logic [CNT_W-1:0] count;
		logic             found;
		logic             flush;
		logic             adv;
	} chain_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/set_signature_lookup_insert_table.sv =====
// Top level of the set signature lookup table: request control and the chain of entries.
`timescale 1ns / 1ps
`default_nettype none

// The table is a chain of MAX_SETS entries, each holding one column mask. A request
// token travels one entry per cycle while the scan is not stalled. The first pass runs
// the full chain of MAX_SETS entries and picks up the mask of set_index; the second pass
// runs from entry 0 up to the entry count, comparing in every entry it visits (in
// supersets mode only from start_index on), and in add or remove mode the entry at the
// end of the used part stores a new mask when nothing matched. A contains test or a
// request with a bad column ends after the first pass, and a request with a bad
// set_index runs neither pass. In supersets mode the scan pauses while a matching word
// waits for the result side. The table needs no clearing after reset; entry 0 starts as
// the empty set. A new request is taken only after the previous one has finished, while
// its last result word may still wait to be taken.
module set_signature_lookup_insert_table import sslit_pkg::*; #(
	parameter int MAX_SETS = MAX_SETS_DEF,
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_ready,
	input  wire logic [1:0] mode,
	input  wire logic [5:0] set_index,
	input  wire logic [5:0] column,
	input  wire logic [6:0] start_index,
	output logic            rsp_valid,
	input  wire logic       rsp_ready,
	output logic [5:0]      result_index,
	output logic            flag,
	output logic [6:0]      next_scan,
	output logic [1:0]      status,
	output logic            last
);

	localparam int CW = $clog2(MAX_SETS + 1);
	localparam int XW = (CW > 7) ? CW : 7;
	localparam int NW = $clog2(RESULT_CAP + 1);
	localparam logic [CW-1:0] SETS = CW'(MAX_SETS);
	localparam logic [NW-1:0] CAP = NW'(RESULT_CAP);
	localparam logic [6:0] COLS = 7'(MAX_COLUMNS);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_FETCH = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_FIN = 2'd3;

	logic [1:0]             state_q;
	logic [1:0]             mode_q;
	logic [5:0]             src_q;
	logic [5:0]             col_q;
	logic [6:0]             start_q;
	logic [MAX_COLUMNS-1:0] key_q;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          pos_q;
	logic                   found_q;
	logic [CW-1:0]          fidx_q;
	logic                   pend_v_q;
	logic [CW-1:0]          pend_idx_q;
	logic [NW-1:0]          n_q;
	logic [5:0]             res_idx_q;
	logic                   res_flag_q;
	logic [6:0]             res_next_q;
	logic [1:0]             res_status_q;
	logic                   rsp_valid_q;
	logic [5:0]             result_index_q;
	logic                   flag_q;
	logic [6:0]             next_scan_q;
	logic [1:0]             status_q;
	logic                   last_q;

	token_t                 tok [0:MAX_SETS];
	logic [MAX_SETS-1:0]    hit_vec;
	logic                   hit_any;
	chain_ctl_t             ctl;
	logic [MAX_COLUMNS-1:0] base;
	logic [MAX_COLUMNS-1:0] bit_v;
	logic                   has_bit;
	logic                   col_bad;
	logic                   sup_mode;
	logic                   scan_end;
	logic                   out_free;
	logic                   stall;
	logic                   push;
	logic                   alloc;
	logic                   cap_stop;
	logic [XW-1:0]          start_x;
	logic [XW-1:0]          cnt_x;
	logic [XW-1:0]          end_x;
	logic [6:0]             nxt_end;

	assign hit_any = |hit_vec;
	assign base = tok[MAX_SETS].key[MAX_COLUMNS-1:0];
	assign bit_v = MAX_COLUMNS'(1) << col_q;
	assign has_bit = |(base & bit_v);
	assign col_bad = ({1'b0, col_q} >= COLS);
	assign sup_mode = (mode_q == MODE_SUPERSETS);
	assign scan_end = (pos_q == count_q);
	assign out_free = !rsp_valid_q || rsp_ready;
	assign cap_stop = hit_any && (n_q == CAP);
	assign stall = (state_q == S_SCAN) && sup_mode && hit_any && pend_v_q && !cap_stop
		&& !out_free;
	assign push = (state_q == S_SCAN) && sup_mode && hit_any && pend_v_q && !cap_stop
		&& out_free;
	assign alloc = (state_q == S_SCAN) && !sup_mode && scan_end && !found_q && (count_q != SETS);
	assign start_x = XW'(start_q);
	assign cnt_x = XW'(count_q);
	assign end_x = (start_x > cnt_x) ? start_x : cnt_x;
	assign nxt_end = 7'(end_x);

	always_comb begin
		tok[0].valid = ((state_q == S_FETCH) || (state_q == S_SCAN)) && (pos_q == '0);
		tok[0].op = TOK_FETCH;
		if (state_q == S_SCAN) begin
			tok[0].op = sup_mode ? TOK_SUPER : TOK_MATCH;
		end
		tok[0].key = KEY_W'(key_q);
	end

	always_comb begin
		ctl.src = CNT_W'(src_q);
		ctl.start = CNT_W'(start_q);
		ctl.count = CNT_W'(count_q);
		ctl.found = found_q;
		ctl.adv = !stall;
		ctl.flush = ((state_q == S_FETCH) && (pos_q == SETS))
			|| ((state_q == S_SCAN) && (scan_end || (sup_mode && cap_stop)));
	end

	for (genvar i = 0; i < MAX_SETS; i++) begin : g_cell
		sslit_cell #(
			.MAX_COLUMNS(MAX_COLUMNS),
			.IDX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.tok_i(tok[i]),
			.tok_o(tok[i+1]),
			.hit(hit_vec[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= MODE_WITH;
			src_q <= '0;
			col_q <= '0;
			start_q <= '0;
			key_q <= '0;
			count_q <= CW'(1);
			pos_q <= '0;
			found_q <= 1'b0;
			fidx_q <= '0;
			pend_v_q <= 1'b0;
			pend_idx_q <= '0;
			n_q <= '0;
			res_idx_q <= '0;
			res_flag_q <= 1'b0;
			res_next_q <= '0;
			res_status_q <= ST_OK;
			rsp_valid_q <= 1'b0;
			result_index_q <= '0;
			flag_q <= 1'b0;
			next_scan_q <= '0;
			status_q <= ST_OK;
			last_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						mode_q <= mode;
						src_q <= set_index;
						col_q <= column;
						start_q <= start_index;
						pos_q <= '0;
						found_q <= 1'b0;
						pend_v_q <= 1'b0;
						n_q <= '0;
						res_idx_q <= '0;
						res_flag_q <= 1'b0;
						res_next_q <= '0;
						if (XW'(set_index) >= XW'(count_q)) begin
							res_status_q <= ST_ERR;
							state_q <= S_FIN;
						end else begin
							res_status_q <= ST_OK;
							state_q <= S_FETCH;
						end
					end
				end
				S_FETCH: begin
					if (pos_q == SETS) begin
						pos_q <= '0;
						if (sup_mode) begin
							key_q <= base;
							state_q <= S_SCAN;
						end else if (col_bad) begin
							res_status_q <= ST_ERR;
							state_q <= S_FIN;
						end else if (mode_q == MODE_CONTAINS) begin
							res_idx_q <= src_q;
							res_flag_q <= has_bit;
							state_q <= S_FIN;
						end else if ((mode_q == MODE_WITH) == has_bit) begin
							res_status_q <= ST_ERR;
							state_q <= S_FIN;
						end else begin
							key_q <= base ^ bit_v;
							state_q <= S_SCAN;
						end
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				S_SCAN: begin
					if (sup_mode) begin
						if (scan_end) begin
							res_idx_q <= pend_v_q ? 6'(pend_idx_q) : 6'd0;
							res_flag_q <= pend_v_q;
							res_next_q <= nxt_end;
							state_q <= S_FIN;
						end else if (cap_stop) begin
							// A further match after a full batch ends the scan there.
							res_idx_q <= 6'(pend_idx_q);
							res_flag_q <= 1'b1;
							res_next_q <= 7'(pos_q);
							state_q <= S_FIN;
						end else if (!stall) begin
							if (hit_any) begin
								pend_v_q <= 1'b1;
								pend_idx_q <= pos_q;
								n_q <= n_q + 1'b1;
							end
							pos_q <= pos_q + 1'b1;
						end
					end else begin
						if (scan_end) begin
							state_q <= S_FIN;
							if (found_q) begin
								res_idx_q <= 6'(fidx_q);
							end else if (count_q == SETS) begin
								res_status_q <= ST_FULL;
							end else begin
								res_idx_q <= 6'(count_q);
								count_q <= count_q + 1'b1;
							end
						end else begin
							if (hit_any) begin
								found_q <= 1'b1;
								fidx_q <= pos_q;
							end
							pos_q <= pos_q + 1'b1;
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						result_index_q <= res_idx_q;
						flag_q <= res_flag_q;
						next_scan_q <= res_next_q;
						status_q <= res_status_q;
						last_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// The held match goes out as soon as a newer match replaces it.
			if (push) begin
				result_index_q <= 6'(pend_idx_q);
				flag_q <= 1'b1;
				next_scan_q <= '0;
				status_q <= ST_OK;
				last_q <= 1'b0;
			end
			if (push || ((state_q == S_FIN) && out_free)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign result_index = result_index_q;
	assign flag = flag_q;
	assign next_scan = next_scan_q;
	assign status = status_q;
	assign last = last_q;

`ifndef NO_ASSERTIONS
	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("More than one entry matched the request token.");

	a_alloc_count: assert property (@(posedge clk) disable iff (!arst_n)
		alloc |=> (count_q == $past(count_q) + 1'b1))
		else $error("Entry count did not advance after an allocation.");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CW'(1)) && (count_q <= SETS))
		else $error("Entry count left its legal range.");

	a_pend_count: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q == (n_q != '0))
		else $error("Held match and match count disagree.");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/sslit_cell.sv =====
// One table entry: holds a mask and passes the request token on to the next entry.
`timescale 1ns / 1ps
`default_nettype none

module sslit_cell import sslit_pkg::*; #(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
	parameter int IDX = 0
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire chain_ctl_t ctl,
	input  wire token_t     tok_i,
	output token_t          tok_o,
	output logic            hit
);

	localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

	logic [MAX_COLUMNS-1:0] mask_q;
	token_t                 tok_q;
	token_t                 tok_d;
	logic [MAX_COLUMNS-1:0] key;
	logic                   live;
	logic                   eq;
	logic                   sup;
	logic                   wr;

	assign key = tok_i.key[MAX_COLUMNS-1:0];
	assign live = tok_i.valid && (MY_IDX < ctl.count);
	assign eq = (mask_q == key);
	assign sup = ((mask_q & key) == key);
	assign wr = ctl.adv && tok_i.valid && (tok_i.op == TOK_MATCH) && (MY_IDX == ctl.count)
		&& !ctl.found;

	always_comb begin
		hit = 1'b0;
		if (live) begin
			case (tok_i.op)
				TOK_MATCH: hit = eq;
				TOK_SUPER: hit = sup && (MY_IDX >= ctl.start);
				default: hit = 1'b0;
			endcase
		end
	end

	always_comb begin
		tok_d = tok_i;
		if (tok_i.valid && (tok_i.op == TOK_FETCH) && (MY_IDX == ctl.src)) begin
			tok_d.key = KEY_W'(mask_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (wr) begin
			mask_q <= key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (ctl.flush) begin
			tok_q.valid <= 1'b0;
		end else if (ctl.adv) begin
			tok_q <= tok_d;
		end
	end

	assign tok_o = tok_q;

endmodule

`default_nettype wire

// ===== sim/tb_set_signature_lookup_insert_table.sv =====
// Self-checking testbench for the set signature lookup table: directed vectors, then random requests.
`timescale 1ns / 1ps

module tb_set_signature_lookup_insert_table import sslit_pkg::*; ();

	localparam int MAX_SETS = MAX_SETS_DEF;
	localparam int MAX_COLUMNS = MAX_COLUMNS_DEF;
	localparam int N_DIRECTED = 24;
	localparam int RANDOM_ITEMS = 206;
	localparam int TAIL_CYCLES = 200;
	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		logic [5:0] idx;
		logic       flag;
		logic [6:0] next_scan;
		logic [1:0] status;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [5:0] set_index;
		logic [5:0] column;
		logic [6:0] start;
		logic       typed;
		result_t    word;
	} vector_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_ready;
	logic [1:0] mode = MODE_CONTAINS;
	logic [5:0] set_index = '0;
	logic [5:0] column = '0;
	logic [6:0] start_index = '0;
	logic       rsp_valid;
	logic       rsp_ready = 1'b0;
	logic [5:0] result_index;
	logic       flag;
	logic [6:0] next_scan;
	logic [1:0] status;
	logic       last;

	logic [63:0] shadow_masks [MAX_SETS];
	int unsigned shadow_count;
	result_t     request_words [$];
	result_t     awaited_words [$];
	int          mismatches = 0;
	int          stall_cycles = 0;
	bit          no_idle = 1'b0;

	set_signature_lookup_insert_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.mode(mode),
		.set_index(set_index),
		.column(column),
		.start_index(start_index),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.result_index(result_index),
		.flag(flag),
		.next_scan(next_scan),
		.status(status),
		.last(last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic result_t word(input int idx, input logic fl, input int nxt,
			input logic [1:0] st, input logic lst);
		result_t r;
		r.idx = idx[5:0];
		r.flag = fl;
		r.next_scan = nxt[6:0];
		r.status = st;
		r.last = lst;
		return r;
	endfunction

	function automatic vector_t row(input logic [1:0] m, input int s, input int c, input int st,
			input logic typed, input result_t w);
		vector_t v;
		v.mode = m;
		v.set_index = s[5:0];
		v.column = c[5:0];
		v.start = st[6:0];
		v.typed = typed;
		v.word = w;
		return v;
	endfunction

	// Computes the result words of one request and updates the shadow table.
	task automatic compute_lookup(input logic [1:0] m, input logic [5:0] s, input logic [5:0] c,
			input logic [6:0] st);
		logic [63:0] base;
		logic [63:0] target;
		int n;
		int nxt;
		int found;
		result_t r;
		request_words.delete();
		if (s >= shadow_count) begin
			request_words.push_back(word(0, 0, 0, ST_ERR, 1));
			return;
		end
		base = shadow_masks[s];
		if (m == MODE_SUPERSETS) begin
			nxt = (st > shadow_count) ? int'(st) : int'(shadow_count);
			n = 0;
			for (int i = st; i < shadow_count; i++) begin
				if ((shadow_masks[i] & base) == base) begin
					if (n == RESULT_CAP) begin
						nxt = i;
						break;
					end
					request_words.push_back(word(i, 1, 0, ST_OK, 0));
					n++;
				end
			end
			if (n == 0) begin
				request_words.push_back(word(0, 0, nxt, ST_OK, 1));
			end else begin
				r = request_words.pop_back();
				r.next_scan = nxt[6:0];
				r.last = 1'b1;
				request_words.push_back(r);
			end
			return;
		end
		if (c >= MAX_COLUMNS) begin
			request_words.push_back(word(0, 0, 0, ST_ERR, 1));
			return;
		end
		if (m == MODE_CONTAINS) begin
			request_words.push_back(word(s, base[c], 0, ST_OK, 1));
			return;
		end
		if ((m == MODE_WITH) ? base[c] : !base[c]) begin
			request_words.push_back(word(0, 0, 0, ST_ERR, 1));
			return;
		end
		target = base ^ (64'd1 << c);
		found = -1;
		for (int i = 0; i < shadow_count; i++) begin
			if (shadow_masks[i] == target) begin
				found = i;
				break;
			end
		end
		if (found >= 0) begin
			request_words.push_back(word(found, 0, 0, ST_OK, 1));
		end else if (shadow_count >= MAX_SETS) begin
			request_words.push_back(word(0, 0, 0, ST_FULL, 1));
		end else begin
			shadow_masks[shadow_count] = target;
			request_words.push_back(word(shadow_count, 0, 0, ST_OK, 1));
			shadow_count++;
		end
	endtask

	task automatic send_request(input vector_t v);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 9) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		mode <= v.mode;
		set_index <= v.set_index;
		column <= v.column;
		start_index <= v.start;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		compute_lookup(v.mode, v.set_index, v.column, v.start);
		if (v.typed) begin
			awaited_words.push_back(v.word);
		end else begin
			foreach (request_words[i]) awaited_words.push_back(request_words[i]);
		end
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (awaited_words.size() != 0) @(negedge clk);
	endtask

	// Columns cluster on the low bits so that lookups often hit existing entries.
	function automatic logic [5:0] pick_column();
		if ($urandom_range(99) < 70) return 6'($urandom_range(7, 0));
		return 6'($urandom_range(63, 0));
	endfunction

	task automatic send_random_request(input int n);
		vector_t v;
		logic [63:0] base;
		int sel;
		v = '0;
		if (shadow_count < MAX_SETS && $urandom_range(99) < 6) begin
			v.set_index = 6'($urandom_range(63, shadow_count));
		end else begin
			v.set_index = 6'($urandom_range(shadow_count - 1, 0));
		end
		base = shadow_masks[v.set_index];
		v.column = pick_column();
		case ($urandom_range(9))
			0: v.start = '0;
			1: v.start = 7'($urandom_range(127, 0));
			default: v.start = 7'($urandom_range(shadow_count, 0));
		endcase
		sel = $urandom_range(99);
		if (sel < ((n < 120) ? 65 : 45)) begin
			v.mode = MODE_WITH;
			if ($urandom_range(9) != 0) begin
				for (int t = 0; t < 12 && base[v.column]; t++) v.column = pick_column();
			end
		end else if (sel < 75) begin
			v.mode = MODE_WITHOUT;
			if ($urandom_range(9) != 0) begin
				for (int t = 0; t < 16 && !base[v.column]; t++) v.column = pick_column();
			end
		end else if (sel < 85) begin
			v.mode = MODE_CONTAINS;
		end else begin
			v.mode = MODE_SUPERSETS;
		end
		send_request(v);
	endtask

	task automatic check_field(input string what, input logic [6:0] want, input logic [6:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	always @(negedge clk) begin
		rsp_ready <= no_idle || ($urandom_range(99) >= 9);
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (awaited_words.size() == 0) begin
				$display("%0t: unexpected word: expected none, actual index %0d status %0d",
					$time, result_index, status);
				mismatches++;
			end else begin
				want = awaited_words.pop_front();
				check_field("result_index", 7'(want.idx), 7'(result_index));
				check_field("flag", 7'(want.flag), 7'(flag));
				check_field("next_scan", want.next_scan, next_scan);
				check_field("status", 7'(want.status), 7'(status));
				check_field("last", 7'(want.last), 7'(last));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles + 1 >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		vector_t directed [N_DIRECTED];
		foreach (shadow_masks[i]) shadow_masks[i] = '0;
		shadow_count = 1;
		directed[0]  = row(MODE_CONTAINS, 0, 0, 0, 1, word(0, 0, 0, ST_OK, 1));
		directed[1]  = row(MODE_CONTAINS, 0, 63, 0, 1, word(0, 0, 0, ST_OK, 1));
		directed[2]  = row(MODE_WITH, 1, 0, 0, 1, word(0, 0, 0, ST_ERR, 1));
		directed[3]  = row(MODE_SUPERSETS, 63, 0, 0, 1, word(0, 0, 0, ST_ERR, 1));
		directed[4]  = row(MODE_SUPERSETS, 0, 0, 0, 1, word(0, 1, 1, ST_OK, 1));
		directed[5]  = row(MODE_WITH, 0, 0, 0, 1, word(1, 0, 0, ST_OK, 1));
		directed[6]  = row(MODE_WITH, 0, 63, 0, 1, word(2, 0, 0, ST_OK, 1));
		directed[7]  = row(MODE_WITH, 1, 63, 0, 0, '0);
		directed[8]  = row(MODE_WITH, 2, 0, 0, 0, '0);
		directed[9]  = row(MODE_WITHOUT, 3, 63, 0, 0, '0);
		directed[10] = row(MODE_WITHOUT, 0, 5, 0, 1, word(0, 0, 0, ST_ERR, 1));
		directed[11] = row(MODE_WITH, 1, 0, 0, 1, word(0, 0, 0, ST_ERR, 1));
		directed[12] = row(MODE_CONTAINS, 3, 63, 0, 0, '0);
		directed[13] = row(MODE_SUPERSETS, 0, 0, 0, 0, '0);
		directed[14] = row(MODE_SUPERSETS, 1, 0, 2, 0, '0);
		directed[15] = row(MODE_SUPERSETS, 2, 0, 64, 1, word(0, 0, 64, ST_OK, 1));
		directed[16] = row(MODE_SUPERSETS, 0, 0, 127, 1, word(0, 0, 127, ST_OK, 1));
		directed[17] = row(MODE_SUPERSETS, 3, 0, 4, 0, '0);
		directed[18] = row(MODE_WITHOUT, 1, 0, 0, 0, '0);
		directed[19] = row(MODE_WITH, 0, 42, 0, 0, '0);
		directed[20] = row(MODE_WITH, 4, 21, 0, 0, '0);
		directed[21] = row(MODE_WITHOUT, 0, 0, 0, 1, word(0, 0, 0, ST_ERR, 1));
		directed[22] = row(MODE_CONTAINS, 62, 0, 0, 1, word(0, 0, 0, ST_ERR, 1));
		directed[23] = row(MODE_SUPERSETS, 5, 0, 0, 0, '0);

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i]) send_request(directed[i]);
		hold_until_drained();
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			no_idle = (n >= 120 && n < 170);
			if (n == 90) hold_until_drained();
			send_random_request(n);
		end
		@(negedge clk);
		req_valid <= 1'b0;
		while (awaited_words.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && awaited_words.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/sslit_pkg.sv
hw/rtl/sslit_cell.sv
hw/rtl/set_signature_lookup_insert_table.sv
sim/tb_set_signature_lookup_insert_table.sv
